FILE: hdl/wmb_pkg.sv
package wmb_pkg;

    localparam int MAX_DIM    = 1024;
    localparam int DIM_W      = $clog2(MAX_DIM);
    localparam int SIZE_W     = DIM_W + 1;
    localparam int CHAN_W     = 16;
    localparam int PIXEL_W    = 3 * CHAN_W;
    localparam int TAP_COUNT  = 5;
    localparam int S_TDATA_W  = PIXEL_W;
    localparam int M_FIELDS_W = PIXEL_W + 2 * DIM_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_DIM);

    // window tap slots
    localparam int TAP_RIGHT       = 0;
    localparam int TAP_DIAG1       = 1;
    localparam int TAP_BELOW_RIGHT = 2;
    localparam int TAP_TWO_BELOW   = 3;
    localparam int TAP_DIAG2       = 4;

    typedef logic [PIXEL_W-1:0] pixel_t;

    typedef struct packed {
        logic row1;   // row i+1 inside the image
        logic row2;   // row i+2 inside the image
        logic col1;   // column j+1 inside the image
        logic col2;   // column j+2 inside the image
    } border_mask_t;

    // configured size clamped to 1..MAX_DIM, minus one
    function automatic logic [DIM_W-1:0] size_minus_one(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] n;
        begin
            n = size;
            if (n == '0) begin
                n = SIZE_W'(1);
            end
            if (n > SIZE_W'(MAX_DIM)) begin
                n = SIZE_W'(MAX_DIM);
            end
            size_minus_one = DIM_W'(n - SIZE_W'(1));
        end
    endfunction

endpackage

FILE: hdl/weighted_3x3_motion_blur_top.sv
// channel  direction  handshake              payload
// s_       in         s_tvalid / s_tready    s_tdata: red_in, green_in, blue_in
// m_       out        m_tvalid / m_tready    m_tdata: red/green/blue_out, out_row, out_column
//                                            m_tlast: frame_last
// cfg_     in         cfg_valid / cfg_ready  cfg_data: image_size
//
// one pixel per cycle unless stalled; the result appears in the cycle after its input
// the two line stores are read ahead at the next column, so no bubble is needed
// the output register stalls the input only while a result is held by m_tready low
// synchronous active-low reset; line stores are not cleared, border masking hides them
// a config write restarts the frame at the bottom-right pixel
module weighted_3x3_motion_blur_top
    import wmb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // red_in, green_in, blue_in

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // red_out, green_out, blue_out, out_row,
                                             // out_column, zero pad
    output logic                  m_tlast,   // frame_last

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [SIZE_W-1:0]     cfg_data   // image_size
);

    logic [SIZE_W-1:0] image_size_reg;
    logic [DIM_W-1:0]  size_m1;
    logic [DIM_W-1:0]  cfg_size_m1;
    logic [DIM_W-1:0]  row_reg, row_next;
    logic [DIM_W-1:0]  col_reg, col_next;
    pixel_t            taps_reg [TAP_COUNT];
    pixel_t            below_rd, two_below_rd;
    pixel_t            filtered;
    border_mask_t      mask;
    logic              accept;
    logic              cfg_write;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tlast_reg;

    assign cfg_ready   = 1'b1;
    assign cfg_write   = cfg_valid && cfg_ready;
    assign s_tready    = !m_tvalid_reg || m_tready;
    assign accept      = s_tvalid && s_tready;
    assign size_m1     = size_minus_one(image_size_reg);
    assign cfg_size_m1 = size_minus_one(cfg_data);

    assign mask.row1 = (row_reg != size_m1);
    assign mask.row2 = ((SIZE_W'(row_reg) + SIZE_W'(2)) <= SIZE_W'(size_m1));
    assign mask.col1 = (col_reg != size_m1);
    assign mask.col2 = ((SIZE_W'(col_reg) + SIZE_W'(2)) <= SIZE_W'(size_m1));

    // counters step right to left, bottom to top
    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        if (cfg_write) begin
            row_next = cfg_size_m1;
            col_next = cfg_size_m1;
        end else if (accept) begin
            if (col_reg == '0) begin
                col_next = size_m1;
                row_next = (row_reg == '0) ? size_m1 : row_reg - DIM_W'(1);
            end else begin
                col_next = col_reg - DIM_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_size_reg <= SIZE_RESET;
            row_reg        <= DIM_W'(MAX_DIM - 1);
            col_reg        <= DIM_W'(MAX_DIM - 1);
            for (int t = 0; t < TAP_COUNT; t++) begin
                taps_reg[t] <= '0;
            end
        end else begin
            row_reg <= row_next;
            col_reg <= col_next;
            if (cfg_write) begin
                image_size_reg <= cfg_data;
                for (int t = 0; t < TAP_COUNT; t++) begin
                    taps_reg[t] <= '0;
                end
            end else if (accept) begin
                taps_reg[TAP_BELOW_RIGHT] <= taps_reg[TAP_DIAG1];
                taps_reg[TAP_DIAG2]       <= taps_reg[TAP_TWO_BELOW];
                taps_reg[TAP_RIGHT]       <= s_tdata;
                taps_reg[TAP_DIAG1]       <= below_rd;
                taps_reg[TAP_TWO_BELOW]   <= two_below_rd;
            end
        end
    end

    // read address runs one column ahead so data is ready at the next transaction
    wmb_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_DIM)) u_store_below (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (s_tdata),
        .rd_addr (col_next),
        .rd_data (below_rd)
    );

    wmb_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_DIM)) u_store_two_below (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (below_rd),
        .rd_addr (col_next),
        .rd_data (two_below_rd)
    );

    wmb_kernel u_kernel (
        .cur    (s_tdata),
        .below  (below_rd),
        .taps   (taps_reg),
        .mask   (mask),
        .result (filtered)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= M_TDATA_W'({col_reg, row_reg, filtered});
            m_tlast_reg <= (row_reg == '0) && (col_reg == '0);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    a_counters_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (row_reg <= size_m1) && (col_reg <= size_m1))
        else $error("pixel counters outside the configured frame");

    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (row_reg == '0) && (col_reg == '0)
        |=> (row_reg == size_m1) && (col_reg == size_m1))
        else $error("counters did not wrap after the last pixel of a frame");

    a_row_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !cfg_valid && (col_reg != '0) |=> row_reg == $past(row_reg))
        else $error("row changed in the middle of a line");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid)
        else $error("accepted transaction produced no result");
`endif

endmodule

FILE: hdl/wmb_ram.sv
module wmb_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/wmb_kernel.sv
module wmb_kernel
    import wmb_pkg::*;
(
    input  pixel_t       cur,
    input  pixel_t       below,
    input  pixel_t       taps [TAP_COUNT],
    input  border_mask_t mask,
    output pixel_t       result
);

    always_comb begin
        logic [CHAN_W-1:0] sum;
        logic [CHAN_W-1:0] p_cur, p_below, p_right, p_diag1, p_br, p_tb, p_diag2;
        result = '0;
        for (int c = 0; c < 3; c++) begin
            p_cur   = cur[c*CHAN_W +: CHAN_W];
            p_below = below[c*CHAN_W +: CHAN_W];
            p_right = taps[TAP_RIGHT][c*CHAN_W +: CHAN_W];
            p_diag1 = taps[TAP_DIAG1][c*CHAN_W +: CHAN_W];
            p_br    = taps[TAP_BELOW_RIGHT][c*CHAN_W +: CHAN_W];
            p_tb    = taps[TAP_TWO_BELOW][c*CHAN_W +: CHAN_W];
            p_diag2 = taps[TAP_DIAG2][c*CHAN_W +: CHAN_W];

            sum = p_cur >> 1;
            if (mask.col1) begin
                sum = sum + (p_right >> 5);
            end
            if (mask.row1) begin
                sum = sum + (p_below >> 5);
            end
            if (mask.row1 && mask.col1) begin
                sum = sum + (p_diag1 >> 2);
            end
            if (mask.row1 && mask.col2) begin
                sum = sum + (p_br >> 5);
            end
            if (mask.row2 && mask.col1) begin
                sum = sum + (p_tb >> 5);
            end
            if (mask.row2 && mask.col2) begin
                sum = sum + (p_diag2 >> 3);
            end
            result[c*CHAN_W +: CHAN_W] = sum;
        end
    end

endmodule

FILE: tb/wmb_checker.sv
`timescale 1ns / 1ps

module wmb_checker
    import wmb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // red_in, green_in, blue_in

    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,   // red_out, green_out, blue_out, out_row,
                                             // out_column, zero pad
    input  logic                  m_tlast,   // frame_last

    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [SIZE_W-1:0]     cfg_data,  // image_size

    output int                    mismatches,
    output int                    pending
);

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [DIM_W-1:0]  row;
        logic [DIM_W-1:0]  column;
        logic              last;
    } blur_result_t;

    blur_result_t      expected_px[$];
    blur_result_t      want;
    logic [SIZE_W-1:0] size_reg;
    pixel_t            below_line [MAX_DIM];
    pixel_t            two_below_line [MAX_DIM];
    pixel_t            taps [TAP_COUNT];
    int                row_idx;
    int                col_idx;
    int                fails;

    function automatic int frame_dim();
        int n;
        n = size_reg;
        if (n == 0) begin
            n = 1;
        end
        if (n > MAX_DIM) begin
            n = MAX_DIM;
        end
        return n;
    endfunction

    function automatic logic [CHAN_W-1:0] chan(input pixel_t px, input int c);
        return px[c*CHAN_W +: CHAN_W];
    endfunction

    task automatic restart_frame();
        row_idx = frame_dim() - 1;
        col_idx = frame_dim() - 1;
        for (int t = 0; t < TAP_COUNT; t++) begin
            taps[t] = '0;
        end
    endtask

    // stencil over the current pixel, the window taps and the two rows below
    task automatic blur_pixel(input pixel_t cur);
        int                n;
        int                i;
        int                j;
        int                sum;
        pixel_t            b1;
        pixel_t            b2;
        logic              r1;
        logic              r2;
        logic              c1;
        logic              c2;
        logic [CHAN_W-1:0] filt [3];
        blur_result_t      res;
        n = frame_dim();
        i = row_idx;
        j = col_idx;
        b1 = below_line[DIM_W'(j)];
        b2 = two_below_line[DIM_W'(j)];
        r1 = (i + 1) < n;
        r2 = (i + 2) < n;
        c1 = (j + 1) < n;
        c2 = (j + 2) < n;
        for (int c = 0; c < 3; c++) begin
            sum = chan(cur, c) >> 1;
            if (c1) begin
                sum = sum + (chan(taps[TAP_RIGHT], c) >> 5);
            end
            if (r1) begin
                sum = sum + (chan(b1, c) >> 5);
            end
            if (r1 && c1) begin
                sum = sum + (chan(taps[TAP_DIAG1], c) >> 2);
            end
            if (r1 && c2) begin
                sum = sum + (chan(taps[TAP_BELOW_RIGHT], c) >> 5);
            end
            if (r2 && c1) begin
                sum = sum + (chan(taps[TAP_TWO_BELOW], c) >> 5);
            end
            if (r2 && c2) begin
                sum = sum + (chan(taps[TAP_DIAG2], c) >> 3);
            end
            filt[c] = CHAN_W'(sum);
        end
        res.red = filt[0];
        res.green = filt[1];
        res.blue = filt[2];
        res.row = DIM_W'(i);
        res.column = DIM_W'(j);
        res.last = (i == 0) && (j == 0);
        expected_px.push_back(res);

        taps[TAP_BELOW_RIGHT] = taps[TAP_DIAG1];
        taps[TAP_DIAG2] = taps[TAP_TWO_BELOW];
        taps[TAP_RIGHT] = cur;
        taps[TAP_DIAG1] = b1;
        taps[TAP_TWO_BELOW] = b2;
        two_below_line[DIM_W'(j)] = b1;
        below_line[DIM_W'(j)] = cur;

        if (j == 0) begin
            col_idx = n - 1;
            row_idx = (i == 0) ? n - 1 : i - 1;
        end else begin
            col_idx = j - 1;
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0h actual %0h",
                     $time, field, exp_val, act_val);
            fails++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_px.delete();
            size_reg = SIZE_RESET;
            restart_frame();
        end else begin
            // the sender must write only while idle, the design does not enforce it; ordering is then moot
            if (cfg_valid && cfg_ready) begin
                size_reg = cfg_data;
                restart_frame();
            end
            if (m_tvalid && m_tready) begin
                if (expected_px.size() == 0) begin
                    $display("%0t: unexpected result transaction, expected none actual %h last %b",
                             $time, m_tdata, m_tlast);
                    fails++;
                end else begin
                    want = expected_px.pop_front();
                    check_field("red_out", want.red, m_tdata[0 +: CHAN_W]);
                    check_field("green_out", want.green, m_tdata[CHAN_W +: CHAN_W]);
                    check_field("blue_out", want.blue, m_tdata[2*CHAN_W +: CHAN_W]);
                    check_field("out_row", want.row, m_tdata[PIXEL_W +: DIM_W]);
                    check_field("out_column", want.column, m_tdata[PIXEL_W+DIM_W +: DIM_W]);
                    check_field("frame_last", want.last, m_tlast);
                end
            end
            if (s_tvalid && s_tready) begin
                blur_pixel(s_tdata);
            end
        end
        mismatches <= fails;
        pending <= expected_px.size();
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import wmb_pkg::*;

    localparam int PIXEL_GOAL = 650;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [SIZE_W-1:0]     cfg_data;
    logic                  calm = 1'b0;
    int                    mismatches;
    int                    pending;
    int                    sent = 0;

    weighted_3x3_motion_blur_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    wmb_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 20);
        end
    end

    function automatic pixel_t corner_pixel(input int k);
        case (k % 4)
            0: return {16'hFFFF, 16'hFFFF, 16'hFFFF};
            1: return '0;
            2: return {16'h5555, 16'hAAAA, 16'hFFFF};
            default: return {16'hAAAA, 16'h5555, 16'h0001};
        endcase
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t px;
        for (int c = 0; c < 3; c++) begin
            case ($urandom_range(9))
                0: px[c*CHAN_W +: CHAN_W] = 16'hFFFF;
                1: px[c*CHAN_W +: CHAN_W] = 16'h0000;
                default: px[c*CHAN_W +: CHAN_W] = CHAN_W'($urandom_range(16'hFFFF, 0));
            endcase
        end
        return px;
    endfunction

    // tvalid stays high across back-to-back transactions
    task automatic send_pixel(input pixel_t px);
        while (!calm && $urandom_range(99) < 20) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= px;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) begin
            @(posedge aclk);
        end
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] size);
        cfg_valid <= 1'b1;
        cfg_data <= size;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int  pick;
        int  dim;
        int  count;
        bit  paused;
        paused = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // reset size: bottom-right corner of a full size frame
        for (int k = 0; k < 3; k++) begin
            send_pixel(corner_pixel(k));
        end
        // all ones everywhere drives the largest sum
        drain();
        write_size(SIZE_W'(3));
        for (int k = 0; k < 9; k++) begin
            send_pixel(corner_pixel(0));
        end
        // wrap into the next frame
        for (int k = 1; k < 5; k++) begin
            send_pixel(corner_pixel(k));
        end
        drain();
        write_size(SIZE_W'(1));
        send_pixel(corner_pixel(0));
        send_pixel(corner_pixel(2));
        // zero size behaves as one
        drain();
        write_size(SIZE_W'(0));
        send_pixel(corner_pixel(3));
        send_pixel(corner_pixel(0));
        // oversize clamps to the maximum
        drain();
        write_size(SIZE_W'(2047));
        send_pixel(corner_pixel(2));
        send_pixel(corner_pixel(3));
        drain();
        write_size(SIZE_W'(2));
        for (int k = 0; k < 3; k++) begin
            send_pixel(corner_pixel(k));
        end

        sent = 0;
        while (sent < PIXEL_GOAL) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                dim = $urandom_range(8, 1);
                count = dim * dim * $urandom_range(3, 1) + $urandom_range(dim, 0);
            end else if (pick < 88) begin
                dim = $urandom_range(16, 9);
                count = dim * $urandom_range(6, 3) + $urandom_range(dim, 0);
            end else if (pick < 93) begin
                dim = MAX_DIM;
                count = $urandom_range(40, 20);
            end else if (pick < 96) begin
                dim = 2047;
                count = $urandom_range(30, 10);
            end else if (pick < 98) begin
                dim = $urandom_range(2046, MAX_DIM + 1);
                count = $urandom_range(30, 10);
            end else begin
                dim = 0;
                count = $urandom_range(6, 2);
            end
            drain();
            write_size(SIZE_W'(dim));
            for (int k = 0; k < count && sent < PIXEL_GOAL; k++) begin
                calm <= (sent >= 250) && (sent < 400);
                // hold off the sender until the pipeline has emptied
                if (k == count / 2 && (!paused || $urandom_range(9) == 0)) begin
                    paused = 1'b1;
                    drain();
                end
                send_pixel(random_pixel());
            end
        end

        drain();
        repeat (5) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
